// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that prop holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that cond never holds outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/cprm_pkg.sv =====
// Package for the chunk point rule matcher: widths, codes, chunk tables,
// the queued command and the stored rule entry. No dependencies.
package cprm_pkg;

  localparam int NumRulesDef = 64;
  localparam int FieldCount  = 5;
  localparam int ChunkCount  = 7;
  localparam int BoundW      = 32;
  localparam int PointW      = 16;
  localparam int RuleIdxW    = 6;
  localparam int FieldIdxW   = 3;
  localparam int MapW        = 64;
  localparam int CntW        = 7;
  localparam int SumW        = 11;
  localparam int ChunkW      = 3;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 7;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  localparam logic [CfgIdxW-1:0] CfgChunk = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClass = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCount = 2'd2;

  typedef struct packed {
    kind_e                 kind;
    logic [RuleIdxW-1:0]   rule;
    logic [FieldIdxW-1:0]  field;
    logic [BoundW-1:0]     lo;
    logic [BoundW-1:0]     hi;
    logic                  minor;
    logic [PointW-1:0]     point;
    logic                  shift_hi;
    logic                  cls;
    logic [CntW-1:0]       n;
  } cmd_t;

  typedef struct packed {
    logic              minor;
    logic [BoundW-1:0] hi;
    logic [BoundW-1:0] lo;
  } entry_t;

  typedef struct packed {
    logic full;
    logic push;
  } fq_stat_t;

  typedef struct packed {
    logic walking;
    logic ram_we;
  } bk_stat_t;

  function automatic logic [FieldIdxW-1:0] chunk_field(input logic [ChunkW-1:0] c);
    logic [FieldIdxW-1:0] f;
    f = '0;
    unique case (c)
      3'd0, 3'd1: f = 3'd0;
      3'd2, 3'd3: f = 3'd1;
      3'd4:       f = 3'd2;
      3'd5:       f = 3'd3;
      3'd6:       f = 3'd4;
      default:    f = 3'd0;
    endcase
    return f;
  endfunction

  function automatic logic chunk_shift_hi(input logic [ChunkW-1:0] c);
    return (c == 3'd1) || (c == 3'd3);
  endfunction

endpackage

// ===== sv/cprm_if.sv =====
// Valid/ready channel interfaces for the matcher's input and result beats.
// Depends on cprm_pkg for field widths.
interface cprm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [cprm_pkg::RuleIdxW-1:0]     rule_index;
  logic [cprm_pkg::FieldIdxW-1:0]    field_index;
  logic [cprm_pkg::BoundW-1:0]       range_low;
  logic [cprm_pkg::BoundW-1:0]       range_high;
  logic                              minor_flag;
  logic [cprm_pkg::PointW-1:0]       point;

  modport source (output valid, kind, rule_index, field_index, range_low, range_high,
                  minor_flag, point, input ready);
  modport sink   (input valid, kind, rule_index, field_index, range_low, range_high,
                  minor_flag, point, output ready);
endinterface

interface cprm_out_if;
  logic                          valid;
  logic                          ready;
  logic [cprm_pkg::MapW-1:0]     match_map;
  logic [cprm_pkg::CntW-1:0]     match_count;
  logic [cprm_pkg::SumW-1:0]     rule_sum;

  modport source (output valid, match_map, match_count, rule_sum, input ready);
  modport sink   (input valid, match_map, match_count, rule_sum, output ready);
endinterface

// ===== sv/cprm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cprm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cprm_front.sv =====
// Front end: configuration registers, item classification and a
// two-entry command queue. Depends on cprm_pkg and cprm_if.
module cprm_front #(
  parameter int NumRules = cprm_pkg::NumRulesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cprm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cprm_pkg::CfgDataW-1:0]  cfg_data_i,
  cprm_in_if.sink                        in_if,
  output cprm_pkg::cmd_t                 cmd_o,
  output logic                           cmd_vld_o,
  input  logic                           cmd_pop_i,
  output cprm_pkg::fq_stat_t             stat_o
);

  localparam int CntW = cprm_pkg::CntW;

  logic [cprm_pkg::ChunkW-1:0] chunk_q;
  logic                        cls_q;
  logic [CntW-1:0]             count_q;

  cprm_pkg::cmd_t cmd_d;
  logic           load_ok;
  logic           chunk_ok;
  logic [CntW-1:0] n_clamp;
  logic           push;

  cprm_pkg::cmd_t q_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     fill_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      cls_q   <= 1'b0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cprm_pkg::CfgChunk: chunk_q <= cfg_data_i[cprm_pkg::ChunkW-1:0];
        cprm_pkg::CfgClass: cls_q   <= cfg_data_i[0];
        cprm_pkg::CfgCount: count_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // classify
  always_comb begin
    chunk_ok = chunk_q < cprm_pkg::ChunkW'(cprm_pkg::ChunkCount);
    n_clamp  = (count_q > CntW'(NumRules)) ? CntW'(NumRules) : count_q;
    load_ok  = (int'(in_if.rule_index) < NumRules) &&
               (int'(in_if.field_index) < cprm_pkg::FieldCount);

    cmd_d.kind  = cprm_pkg::kind_e'(in_if.kind);
    cmd_d.rule  = in_if.rule_index;
    cmd_d.lo    = in_if.range_low;
    cmd_d.hi    = in_if.range_high;
    cmd_d.minor = in_if.minor_flag;
    cmd_d.point = in_if.point;
    cmd_d.cls   = cls_q;
    if (cmd_d.kind == cprm_pkg::KIND_LOAD) begin
      cmd_d.field    = in_if.field_index;
      cmd_d.shift_hi = 1'b0;
      cmd_d.n        = '0;
    end else begin
      cmd_d.field    = cprm_pkg::chunk_field(chunk_q);
      cmd_d.shift_hi = cprm_pkg::chunk_shift_hi(chunk_q);
      cmd_d.n        = chunk_ok ? n_clamp : '0;
    end
  end

  assign in_if.ready = (fill_q != 2'd2);
  assign push = in_if.valid && in_if.ready &&
                ((cmd_d.kind == cprm_pkg::KIND_QUERY) || load_ok);

  // command queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  assign cmd_o     = q_q[rd_ptr_q];
  assign cmd_vld_o = (fill_q != 2'd0);
  assign stat_o    = '{full: (fill_q == 2'd2), push: push};

endmodule

// ===== sv/cprm_back.sv =====
// Back end: executes loads into the rule store and walks the store one
// rule per cycle for queries; holds the result beat. Depends on cprm_pkg.
module cprm_back #(
  parameter int NumRules = cprm_pkg::NumRulesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cprm_pkg::cmd_t        cmd_i,
  input  logic                  cmd_vld_i,
  output logic                  cmd_pop_o,
  output logic                  ram_we_o,
  output logic [$clog2(NumRules*cprm_pkg::FieldCount)-1:0] ram_waddr_o,
  output cprm_pkg::entry_t      ram_wdata_o,
  output logic                  ram_re_o,
  output logic [$clog2(NumRules*cprm_pkg::FieldCount)-1:0] ram_raddr_o,
  input  cprm_pkg::entry_t      ram_rdata_i,
  cprm_out_if.source            out_if,
  output cprm_pkg::bk_stat_t    stat_o
);

  localparam int AddrW = $clog2(NumRules * cprm_pkg::FieldCount);
  localparam int IdxW  = (NumRules > 1) ? $clog2(NumRules) : 1;
  localparam int CntW  = cprm_pkg::CntW;
  localparam int SumW  = cprm_pkg::SumW;
  localparam int MapW  = cprm_pkg::MapW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e           st_q, st_d;
  cprm_pkg::cmd_t   qry_q, qry_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [IdxW-1:0]  issue_q, issue_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  pend_idx_q, pend_idx_d;
  logic [NumRules-1:0] map_q, map_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic             out_vld_q, out_vld_d;
  logic [MapW-1:0]  out_map_q, out_map_d;
  logic [CntW-1:0]  out_cnt_q, out_cnt_d;
  logic [SumW-1:0]  out_sum_q, out_sum_d;

  logic [cprm_pkg::PointW-1:0] lo16, hi16;
  logic                        hit;

  always_comb begin
    lo16 = qry_q.shift_hi ? ram_rdata_i.lo[31:16] : ram_rdata_i.lo[15:0];
    hi16 = qry_q.shift_hi ? ram_rdata_i.hi[31:16] : ram_rdata_i.hi[15:0];
    hit  = (ram_rdata_i.minor == qry_q.cls) && (lo16 <= qry_q.point) &&
           (qry_q.point <= hi16);
  end

  always_comb begin
    st_d       = st_q;
    qry_d      = qry_q;
    addr_d     = addr_q;
    issue_d    = issue_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    map_d      = map_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    out_vld_d  = out_vld_q && !out_if.ready;
    out_map_d  = out_map_q;
    out_cnt_d  = out_cnt_q;
    out_sum_d  = out_sum_q;
    cmd_pop_o  = 1'b0;
    ram_we_o   = 1'b0;
    ram_re_o   = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == cprm_pkg::KIND_LOAD) begin
            ram_we_o = 1'b1;
          end else begin
            qry_d   = cmd_i;
            addr_d  = AddrW'(cmd_i.field);
            issue_d = '0;
            map_d   = '0;
            cnt_d   = '0;
            sum_d   = '0;
            st_d    = (cmd_i.n == '0) ? S_DONE : S_WALK;
          end
        end
      end
      S_WALK: begin
        ram_re_o   = 1'b1;
        pend_d     = 1'b1;
        pend_idx_d = issue_q;
        issue_d    = issue_q + 1'b1;
        addr_d     = addr_q + AddrW'(cprm_pkg::FieldCount);
        if (CntW'(issue_q) == qry_q.n - 1'b1) begin
          st_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        st_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || out_if.ready) begin
          out_vld_d = 1'b1;
          out_map_d = MapW'(map_q);
          out_cnt_d = cnt_q;
          out_sum_d = sum_q;
          st_d      = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase

    if (pend_q && hit) begin
      map_d[pend_idx_q] = 1'b1;
      cnt_d = cnt_q + 1'b1;
      sum_d = sum_q + SumW'(pend_idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q      <= qry_d;
    addr_q     <= addr_d;
    issue_q    <= issue_d;
    pend_idx_q <= pend_idx_d;
    map_q      <= map_d;
    cnt_q      <= cnt_d;
    sum_q      <= sum_d;
    out_map_q  <= out_map_d;
    out_cnt_q  <= out_cnt_d;
    out_sum_q  <= out_sum_d;
  end

  assign ram_waddr_o = AddrW'(int'(cmd_i.rule) * cprm_pkg::FieldCount + int'(cmd_i.field));
  assign ram_wdata_o = '{minor: cmd_i.minor, hi: cmd_i.hi, lo: cmd_i.lo};
  assign ram_raddr_o = addr_q;

  assign out_if.valid       = out_vld_q;
  assign out_if.match_map   = out_map_q;
  assign out_if.match_count = out_cnt_q;
  assign out_if.rule_sum    = out_sum_q;

  assign stat_o = '{walking: (st_q == S_WALK), ram_we: ram_we_o};

endmodule

// ===== sv/chunk_point_rule_matcher.sv =====
// Top level of the chunk point rule matcher: front end, rule store, back end.
// Depends on cprm_pkg, cprm_if, cprm_ram, cprm_front, cprm_back, assert_macros.svh.
//
//   channel   dir  handshake       payload
//   in_if     in   valid/ready     kind, rule/field index, bounds, minor flag, point
//   out_if    out  valid/ready     match_map, match_count, rule_sum (one per query)
//   cfg       in   cfg_we_i        cfg_idx_i, cfg_data_i
//
// The back end takes an item from the queue whenever it is idle. A load writes the
// rule store at once; a query walks n rules, n being rule_count clamped to NumRules,
// then drains and finishes, or finishes at once when n is zero or the chunk is seven.
// The input stalls while the two-entry queue is full; the result register lets the
// back end keep executing loads while a result beat waits.
// Reset clears control and configuration; the rule store is not cleared.
`include "assert_macros.svh"

module chunk_point_rule_matcher #(
  parameter int NumRules = cprm_pkg::NumRulesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cprm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cprm_pkg::CfgDataW-1:0]  cfg_data_i,
  cprm_in_if.sink                        in_if,
  cprm_out_if.source                     out_if
);

  localparam int Depth = NumRules * cprm_pkg::FieldCount;
  localparam int AddrW = $clog2(Depth);

  cprm_pkg::cmd_t     cmd;
  logic               cmd_vld, cmd_pop;
  cprm_pkg::fq_stat_t fq_stat;
  cprm_pkg::bk_stat_t bk_stat;
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  cprm_pkg::entry_t   ram_wdata, ram_rdata;

  cprm_front #(.NumRules(NumRules)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if     (in_if),
    .cmd_o     (cmd),
    .cmd_vld_o (cmd_vld),
    .cmd_pop_i (cmd_pop),
    .stat_o    (fq_stat)
  );

  cprm_ram #(.Width($bits(cprm_pkg::entry_t)), .Depth(Depth)) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cprm_back #(.NumRules(NumRules)) u_back (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .cmd_vld_i   (cmd_vld),
    .cmd_pop_o   (cmd_pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_if      (out_if),
    .stat_o      (bk_stat)
  );

  `ASSERT_ALWAYS(a_count_matches_map, out_if.valid |-> ($countones(out_if.match_map) == int'(out_if.match_count)), "match_count disagrees with match_map")
  `ASSERT_ALWAYS(a_count_bound, out_if.valid |-> (int'(out_if.match_count) <= NumRules), "match_count above rule table size")
  `ASSERT_NEVER(a_no_write_in_walk, bk_stat.walking && bk_stat.ram_we, "rule store written during a walk")
  `ASSERT_NEVER(a_no_push_full, fq_stat.full && fq_stat.push, "command queue overflow")

endmodule
